/* sv/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, command and status codes, and interface types for the
// double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_FRONT      = 3'd4;
  localparam logic [2:0] CMD_BACK       = 3'd5;
  localparam logic [2:0] CMD_SIZE       = 3'd6;
  localparam logic [2:0] CMD_EMPTY      = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam word_t WORD_NEG_ONE = '1;

  // Memory access issued by the controller in the cycle a request is taken.
  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    word_t wr_data;
    logic  rd_en;
    addr_t rd_addr;
  } mem_req_t;

  // Registered response; from_ram selects the memory read data as value.
  typedef struct packed {
    logic       done;
    logic       from_ram;
    logic [1:0] status;
    word_t      value;
  } rsp_t;

endpackage

/* sv/dq_ram.sv */
// ----------------------------------------------------------------------------
// dq_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/dq_ctrl.sv */
// ----------------------------------------------------------------------------
// dq_ctrl
// Head pointer and entry count, command decode, ring address generation and
// the response register.
// ----------------------------------------------------------------------------
module dq_ctrl
  import dq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [2:0] cmd,
  input  word_t      push_value,
  output mem_req_t   mem_req,
  output rsp_t       rsp
);

  localparam int SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

  addr_t head, head_next;
  cnt_t  count, count_next;
  rsp_t  rsp_next;

  logic  is_empty, is_full;
  addr_t head_dec, head_inc, tail_pos, back_pos;
  logic [SUM_W-1:0] sum_tail, sum_back;

  // Fold a sum below twice the depth back into the ring.
  function automatic addr_t wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
    return r[ADDR_W-1:0];
  endfunction

  always_comb begin
    is_empty = (count == '0);
    is_full  = (count == CNT_W'(DEPTH));
    head_dec = (head == '0) ? ADDR_W'(DEPTH - 1) : head - 1'b1;
    head_inc = (head == ADDR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
    sum_tail = SUM_W'(head) + SUM_W'(count);
    sum_back = sum_tail - 1'b1;
    tail_pos = wrap(sum_tail);
    back_pos = wrap(sum_back);
  end

  always_comb begin
    head_next        = head;
    count_next       = count;
    mem_req          = '0;
    mem_req.wr_data  = push_value;
    rsp_next         = '0;
    rsp_next.done    = take;
    rsp_next.status  = ST_OK;
    if (take) begin
      case (cmd)
        CMD_PUSH_BACK: begin
          if (is_full) begin
            rsp_next.status = ST_FULL;
          end else begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = tail_pos;
            count_next      = count + 1'b1;
          end
        end
        CMD_PUSH_FRONT: begin
          if (is_full) begin
            rsp_next.status = ST_FULL;
          end else begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = head_dec;
            head_next       = head_dec;
            count_next      = count + 1'b1;
          end
        end
        CMD_POP_FRONT, CMD_FRONT: begin
          if (is_empty) begin
            rsp_next.status = ST_EMPTY;
            rsp_next.value  = WORD_NEG_ONE;
          end else begin
            mem_req.rd_en     = 1'b1;
            mem_req.rd_addr   = head;
            rsp_next.from_ram = 1'b1;
            if (cmd == CMD_POP_FRONT) begin
              head_next  = head_inc;
              count_next = count - 1'b1;
            end
          end
        end
        CMD_POP_BACK, CMD_BACK: begin
          if (is_empty) begin
            rsp_next.status = ST_EMPTY;
            rsp_next.value  = WORD_NEG_ONE;
          end else begin
            mem_req.rd_en     = 1'b1;
            mem_req.rd_addr   = back_pos;
            rsp_next.from_ram = 1'b1;
            if (cmd == CMD_POP_BACK) begin
              count_next = count - 1'b1;
            end
          end
        end
        CMD_SIZE: begin
          rsp_next.value = WORD_W'(count);
        end
        CMD_EMPTY: begin
          rsp_next.value = WORD_W'(is_empty);
        end
        default: begin
          rsp_next.value = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      rsp.done <= 1'b0;
    end else begin
      head     <= head_next;
      count    <= count_next;
      rsp.done <= rsp_next.done;
    end
    rsp.from_ram <= rsp_next.from_ram;
    rsp.status   <= rsp_next.status;
    rsp.value    <= rsp_next.value;
  end

endmodule

/* sv/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of signed 32-bit words in a ring memory.
// ----------------------------------------------------------------------------
// A request (start high while busy is low) carries cmd and push_value and
// yields exactly one result in the next cycle: done is high for that single
// cycle with result_value and status valid. The receiver cannot stall, so
// take the result in the cycle done is high. busy stays low: one request is
// taken every cycle, and the timing of each result is always set by the single
// registered read port of the ring memory. A push written in a cycle is
// visible to a pop or peek in the next, since the write lands in the memory
// before that read is issued. Pops and peeks on an empty queue answer -1
// with status empty; pushes on a full queue are dropped with status full.
// The ring needs no clearing after reset: only entries filled by a push are
// ever read.
// ----------------------------------------------------------------------------
module double_ended_queue
  import dq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] cmd,
  input  word_t      push_value,
  output logic       done,
  output word_t      result_value,
  output logic [1:0] status
);

  mem_req_t mem_req;
  rsp_t     rsp;
  word_t    rd_data;
  logic     take;

  // Never hold off a request: every command settles in one memory access.
  assign busy = 1'b0;
  assign take = start & ~busy;

  dq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .cmd        (cmd),
    .push_value (push_value),
    .mem_req    (mem_req),
    .rsp        (rsp)
  );

  dq_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (WORD_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  // Steer the popped or peeked word from the memory; otherwise drive the
  // value computed by the controller.
  assign done         = rsp.done;
  assign status       = rsp.status;
  assign result_value = rsp.from_ram ? rd_data : rsp.value;

endmodule
